// ----- rtl/dsub_pkg.sv -----
// ----------------------------------------------------------------------------
// dsub_pkg: shared types for the 4-bit pixel code string decoder
// Beat payloads, result kinds and queue sizing used across the block.
// ----------------------------------------------------------------------------
package dsub_pkg;

    localparam logic [1:0] KIND_RUN     = 2'd0;
    localparam logic [1:0] KIND_EOS     = 2'd1;
    localparam logic [1:0] KIND_EOL     = 2'd2;
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    localparam logic [8:0] MAX_RUN_LEN = 9'd280;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       block_start;
    } t_in;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [8:0] run_len;
        logic [3:0] pix_code;
        logic       last_of_item;
    } t_out;

    // Results of one byte, compacted: second slot used only with the first.
    typedef struct packed {
        logic v0;
        logic v1;
        t_out d0;
        t_out d1;
    } t_push;

    typedef struct packed {
        logic valid;
        t_out data;
    } t_head;

endpackage

// ----- rtl/dsub_front.sv -----
// ----------------------------------------------------------------------------
// dsub_front: byte parser
// Classifies each byte and decodes both nibbles into up to two results.
// ----------------------------------------------------------------------------
module dsub_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  dsub_pkg::t_in  i_in,
    output dsub_pkg::t_push o_push
);
    import dsub_pkg::*;

    localparam logic [3:0] PH_TYPE  = 4'd0;
    localparam logic [3:0] PH_FIRST = 4'd1;
    localparam logic [3:0] PH_CTRL  = 4'd2;
    localparam logic [3:0] PH_LEN9  = 4'd3;
    localparam logic [3:0] PH_LENHI = 4'd4;
    localparam logic [3:0] PH_LENLO = 4'd5;
    localparam logic [3:0] PH_PIX   = 4'd6;

    localparam logic [7:0] TYPE_STRING4 = 8'h11;
    localparam logic [7:0] TYPE_EOL     = 8'hf0;

    localparam logic [8:0] OFS_SHORT = 9'd4;
    localparam logic [8:0] OFS_MID   = 9'd9;
    localparam logic [8:0] OFS_LONG  = 9'd25;

    typedef struct packed {
        logic [3:0] phase;
        logic [3:0] ctrl;
        logic [7:0] run;
    } t_pstate;

    typedef struct packed {
        t_pstate st;
        logic    v;
        t_out    res;
    } t_nib;

    function automatic t_out mk(input logic [1:0] kind, input logic [8:0] len,
                                input logic [3:0] code);
        t_out r;
        r.result_kind  = kind;
        r.run_len      = len;
        r.pix_code     = code;
        r.last_of_item = 1'b0;
        return r;
    endfunction

    function automatic t_nib step(input t_pstate s, input logic [3:0] nib);
        t_nib       r;
        logic [8:0] len;
        r.st  = s;
        r.v   = 1'b0;
        r.res = '0;
        len   = '0;
        case (s.phase)
            PH_FIRST: begin
                if (nib != 4'd0) begin
                    r.v   = 1'b1;
                    r.res = mk(KIND_RUN, 9'd1, nib);
                end else begin
                    r.st.phase = PH_CTRL;
                end
            end
            PH_CTRL: begin
                r.st.ctrl = nib;
                if (!nib[3]) begin
                    r.v = 1'b1;
                    if (nib[2:0] != 3'd0) begin
                        r.res      = mk(KIND_RUN, {6'd0, nib[2:0]} + 9'd2, 4'd0);
                        r.st.phase = PH_FIRST;
                    end else begin
                        r.res      = mk(KIND_EOS, 9'd0, 4'd0);
                        r.st.phase = PH_TYPE;
                    end
                end else if (!nib[2]) begin
                    r.st.run   = {6'd0, nib[1:0]};
                    r.st.phase = PH_PIX;
                end else begin
                    case (nib[1:0])
                        2'd0: begin
                            r.v        = 1'b1;
                            r.res      = mk(KIND_RUN, 9'd1, 4'd0);
                            r.st.phase = PH_FIRST;
                        end
                        2'd1: begin
                            r.v        = 1'b1;
                            r.res      = mk(KIND_RUN, 9'd2, 4'd0);
                            r.st.phase = PH_FIRST;
                        end
                        2'd2:    r.st.phase = PH_LEN9;
                        default: r.st.phase = PH_LENHI;
                    endcase
                end
            end
            PH_LEN9: begin
                r.st.run   = {4'd0, nib};
                r.st.phase = PH_PIX;
            end
            PH_LENHI: begin
                r.st.run   = {nib, 4'd0};
                r.st.phase = PH_LENLO;
            end
            PH_LENLO: begin
                r.st.run   = s.run | {4'd0, nib};
                r.st.phase = PH_PIX;
            end
            PH_PIX: begin
                if (!s.ctrl[2]) begin
                    len = {7'd0, s.run[1:0]} + OFS_SHORT;
                end else if (s.ctrl[1:0] == 2'd2) begin
                    len = {5'd0, s.run[3:0]} + OFS_MID;
                end else begin
                    len = {1'b0, s.run} + OFS_LONG;
                end
                r.v        = 1'b1;
                r.res      = mk(KIND_RUN, len, nib);
                r.st.phase = PH_FIRST;
            end
            default: r.st.phase = PH_TYPE;
        endcase
        return r;
    endfunction

    t_pstate r_st, n_st;
    t_pstate s0;
    t_nib    a, b;
    t_push   p;

    always_comb begin
        s0 = r_st;
        if (i_in.block_start) begin
            s0 = '0;
        end
        a = '0;
        b = '0;
        p = '0;
        if (s0.phase == PH_TYPE || s0.phase > PH_PIX) begin
            n_st       = s0;
            n_st.phase = PH_TYPE;
            p.v0       = 1'b1;
            if (i_in.data_byte == TYPE_STRING4) begin
                n_st.phase = PH_FIRST;
                p.v0       = 1'b0;
            end else if (i_in.data_byte == TYPE_EOL) begin
                p.d0 = mk(KIND_EOL, 9'd0, 4'd0);
            end else begin
                p.d0 = mk(KIND_UNKNOWN, 9'd0, 4'd0);
            end
            p.d0.last_of_item = 1'b1;
        end else begin
            a    = step(s0, i_in.data_byte[7:4]);
            n_st = a.st;
            if (a.st.phase != PH_TYPE) begin
                b    = step(a.st, i_in.data_byte[3:0]);
                n_st = b.st;
            end
            // compact: the second nibble's result moves down when the first had none
            if (a.v) begin
                p.v0 = 1'b1;
                p.d0 = a.res;
                p.v1 = b.v;
                p.d1 = b.res;
                p.d1.last_of_item = 1'b1;
                p.d0.last_of_item = !b.v;
            end else begin
                p.v0 = b.v;
                p.d0 = b.res;
                p.d0.last_of_item = 1'b1;
            end
        end
        o_push    = p;
        o_push.v0 = p.v0 && i_accept;
        o_push.v1 = p.v1 && i_accept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (i_accept) begin
            r_st <= n_st;
        end
    end

endmodule

// ----- rtl/dsub_queue.sv -----
// ----------------------------------------------------------------------------
// dsub_queue: result queue
// Takes up to two results per cycle from the parser, hands on one per cycle when popped.
// ----------------------------------------------------------------------------
module dsub_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dsub_pkg::t_push i_push,
    input  logic            i_pop,
    output dsub_pkg::t_head o_head,
    output logic            o_room
);
    import dsub_pkg::*;

    t_out                r_mem [Q_DEPTH];
    logic [Q_AW-1:0]     r_wr, n_wr;
    logic [Q_AW-1:0]     r_rd, n_rd;
    logic [Q_AW:0]       r_count, n_count;
    logic                pop_ok;

    assign pop_ok = i_pop && (r_count != '0);

    always_comb begin
        n_wr    = r_wr + Q_AW'({1'b0, i_push.v0}) + Q_AW'({1'b0, i_push.v1});
        n_rd    = r_rd + Q_AW'({1'b0, pop_ok});
        n_count = r_count + (Q_AW+1)'(i_push.v0) + (Q_AW+1)'(i_push.v1)
                  - (Q_AW+1)'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wr] <= i_push.d0;
        end
        if (i_push.v1) begin
            r_mem[r_wr + Q_AW'(1)] <= i_push.d1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.data  = r_mem[r_rd];
    // room for a full byte's worth of results
    assign o_room = (r_count <= (Q_AW+1)'(Q_DEPTH - 2));

endmodule

// ----- rtl/dsub_back.sv -----
// ----------------------------------------------------------------------------
// dsub_back: result output stage
// Pulls results from the queue into the output register, one per beat.
// ----------------------------------------------------------------------------
module dsub_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dsub_pkg::t_head i_head,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output dsub_pkg::t_out  o_out
);
    import dsub_pkg::*;

    logic r_valid, n_valid;
    t_out r_data;

    assign o_pop   = i_head.valid && (!r_valid || i_out_ready);
    assign n_valid = o_pop || (r_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_head.data;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out       = r_data;

endmodule

// ----- rtl/dvb_subtitle_4bit_run_decoder.sv -----
// ----------------------------------------------------------------------------
// dvb_subtitle_4bit_run_decoder: DVB subtitle 4-bit pixel code string decoder
// Turns pixel-data sub-block bytes into runs and control results.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in): one sub-block byte per
//   beat, with block_start set on the first byte of each sub-block.
//   Output channel (o_out_valid / i_out_ready / o_out): one result per beat,
//   a pixel run or an end-of-string, end-of-line or unknown-type marker;
//   last_of_item flags the final result of its byte. A byte gives 0 to 2.
//   Results of a byte are registered in the queue and then in the output
//   register. The output gives one result per cycle while the receiver is
//   ready, set by the single output register; the parser can take a new
//   byte while earlier results still wait in the queue.
//   The parser writes both results of a byte into a four-entry queue in the
//   same cycle; o_in_ready drops while fewer than two entries are free.
//   Reset (synchronous, active low): parser back to expecting a data type,
//   queue emptied, output invalid.
//   Receiver stall: the output beat holds; the queue absorbs the backlog and
//   the input side stalls only once the queue is near full.
// ----------------------------------------------------------------------------
module dvb_subtitle_4bit_run_decoder (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  dsub_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output dsub_pkg::t_out o_out
);
    import dsub_pkg::*;

    t_push push;
    t_head head;
    logic  pop;
    logic  room;
    logic  accept;

    // take a byte only when its worst-case two results fit
    assign o_in_ready = room;
    assign accept     = i_in_valid && room;

    // front: classify the byte and decode both nibbles
    dsub_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_in     (i_in),
        .o_push   (push)
    );

    // decouple parser and output so each can stall on its own
    dsub_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_room  (room)
    );

    // back: drain one result per beat into the output register
    dsub_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

// ----- rtl/dsub_checker.sv -----
// ----------------------------------------------------------------------------
// dsub_checker: port-level checks for the decoder
// Watches the top-level ports and flags malformed results.
// ----------------------------------------------------------------------------
module dsub_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input dsub_pkg::t_out o_out
);
    import dsub_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("output beat changed while stalled");

    // nothing is shown right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // run length is nonzero exactly on runs
    a_len_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out.result_kind == KIND_RUN) == (o_out.run_len != 9'd0)))
        else $error("run length does not match result kind");

    // markers carry no colour and always end their byte
    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.result_kind != KIND_RUN
        |-> o_out.pix_code == 4'd0 && o_out.last_of_item)
        else $error("marker result malformed");

    a_len_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.run_len <= MAX_RUN_LEN)
        else $error("run length out of range");

endmodule

bind dvb_subtitle_4bit_run_decoder dsub_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
